// ===== sv/ufr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ufr_pkg;

    // Frame sync bytes and the reset value of the payload limit.
    localparam logic [7:0]  SYNC_FIRST       = 8'hB5;
    localparam logic [7:0]  SYNC_SECOND      = 8'h62;
    localparam logic [15:0] MAX_LENGTH_RESET = 16'd512;

    // Event codes carried in tuser.
    localparam logic [1:0] EV_PAYLOAD  = 2'd0;
    localparam logic [1:0] EV_GOOD     = 2'd1;
    localparam logic [1:0] EV_BAD      = 2'd2;
    localparam logic [1:0] EV_TOO_LONG = 2'd3;

    // Parser phase codes.
    localparam logic [3:0] PH_SYNC1   = 4'd0;
    localparam logic [3:0] PH_SYNC2   = 4'd1;
    localparam logic [3:0] PH_CLASS   = 4'd2;
    localparam logic [3:0] PH_ID      = 4'd3;
    localparam logic [3:0] PH_LEN_LO  = 4'd4;
    localparam logic [3:0] PH_LEN_HI  = 4'd5;
    localparam logic [3:0] PH_PAYLOAD = 4'd6;
    localparam logic [3:0] PH_CK_A    = 4'd7;
    localparam logic [3:0] PH_CK_B    = 4'd8;

    // Result item fields, last field in the lowest bits.
    typedef struct packed {
        logic [7:0]  sum_b;
        logic [7:0]  sum_a;
        logic [7:0]  payload_byte;
        logic [15:0] byte_index;
        logic [15:0] payload_length;
        logic [7:0]  msg_id;
        logic [7:0]  msg_class;
    } result_t;

endpackage

`default_nettype wire

// ===== sv/ubx_frame_receiver.sv =====
`timescale 1ns / 1ps
`default_nettype none

// A result item is valid in the cycle after the byte that causes it is accepted.
// Throughput: one received byte per cycle while ready; the phase register sets this.
// The input is ready whenever the result register is empty or being drained.
// Reset (rst_n low, asynchronous) returns the parser to sync hunting, clears sums,
// empties the result register and restores the payload limit to 512.
module ubx_frame_receiver
    import ufr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Received bytes.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    // Result items.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [7:0] msg_class, [15:8] msg_id, [31:16] payload_length, [47:32] byte_index,
    // [55:48] payload_byte, [63:56] sum_a, [71:64] sum_b
    output logic [71:0]      m_axis_tdata,
    output logic [1:0]       m_axis_tuser,   // [1:0] event_kind
    // Payload limit register write.
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data        // max_payload_length
);

    logic [15:0] max_len_reg;
    logic [3:0]  phase_reg,     phase_next;
    logic [7:0]  class_reg,     class_next;
    logic [7:0]  id_reg,        id_next;
    logic [15:0] length_reg,    length_next;
    logic [15:0] count_reg,     count_next;
    logic [7:0]  sum_a_reg,     sum_a_next;
    logic [7:0]  sum_b_reg,     sum_b_next;
    logic [7:0]  rx_sum_a_reg,  rx_sum_a_next;
    logic        out_valid_reg;
    logic [1:0]  out_kind_reg,  out_kind_next;
    result_t     out_data_reg,  out_data_next;
    logic        emit;
    logic        in_accept;
    logic [7:0]  rx;
    logic [7:0]  add_a;
    logic [15:0] full_length;
    logic [15:0] count_inc;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_kind_reg;

    assign rx          = s_axis_tdata;
    assign add_a       = sum_a_reg + rx;
    assign full_length = {rx, length_reg[7:0]};
    assign count_inc   = count_reg + 16'd1;

    // Payload limit register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_LENGTH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_len_reg <= cfg_data;
        end
    end

    // Parser next state and result for the byte at the input.
    always_comb
    begin
        phase_next    = phase_reg;
        class_next    = class_reg;
        id_next       = id_reg;
        length_next   = length_reg;
        count_next    = count_reg;
        sum_a_next    = sum_a_reg;
        sum_b_next    = sum_b_reg;
        rx_sum_a_next = rx_sum_a_reg;
        emit          = 1'b0;
        out_kind_next = EV_PAYLOAD;
        out_data_next = '0;

        unique case (phase_reg)
            PH_SYNC2:
            begin
                phase_next = (rx == SYNC_SECOND) ? PH_CLASS : PH_SYNC1;
            end
            PH_CLASS:
            begin
                class_next = rx;
                sum_a_next = add_a;
                sum_b_next = sum_b_reg + add_a;
                phase_next = PH_ID;
            end
            PH_ID:
            begin
                id_next    = rx;
                sum_a_next = add_a;
                sum_b_next = sum_b_reg + add_a;
                phase_next = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                length_next = {8'd0, rx};
                sum_a_next  = add_a;
                sum_b_next  = sum_b_reg + add_a;
                phase_next  = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                length_next = full_length;
                sum_a_next  = add_a;
                sum_b_next  = sum_b_reg + add_a;
                count_next  = '0;
                if (full_length > max_len_reg)
                begin
                    emit          = 1'b1;
                    out_kind_next = EV_TOO_LONG;
                    phase_next    = PH_SYNC1;
                end
                else if (full_length == 16'd0)
                begin
                    phase_next = PH_CK_A;
                end
                else
                begin
                    phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                sum_a_next                 = add_a;
                sum_b_next                 = sum_b_reg + add_a;
                emit                       = 1'b1;
                out_kind_next              = EV_PAYLOAD;
                out_data_next.byte_index   = count_reg;
                out_data_next.payload_byte = rx;
                count_next                 = count_inc;
                if (count_inc >= length_reg)
                begin
                    phase_next = PH_CK_A;
                end
            end
            PH_CK_A:
            begin
                rx_sum_a_next = rx;
                phase_next    = PH_CK_B;
            end
            PH_CK_B:
            begin
                emit                = 1'b1;
                out_kind_next       = ((rx_sum_a_reg == sum_a_reg) && (rx == sum_b_reg))
                                      ? EV_GOOD : EV_BAD;
                out_data_next.sum_a = sum_a_reg;
                out_data_next.sum_b = sum_b_reg;
                phase_next          = PH_SYNC1;
            end
            default:
            begin
                // Sync hunting; unused phase codes behave the same way.
                sum_a_next = '0;
                sum_b_next = '0;
                phase_next = (rx == SYNC_FIRST) ? PH_SYNC2 : PH_SYNC1;
            end
        endcase

        out_data_next.msg_class      = class_next;
        out_data_next.msg_id         = id_next;
        out_data_next.payload_length = length_next;
    end

    // Parser state, updated once per accepted item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_SYNC1;
            class_reg    <= '0;
            id_reg       <= '0;
            length_reg   <= '0;
            count_reg    <= '0;
            sum_a_reg    <= '0;
            sum_b_reg    <= '0;
            rx_sum_a_reg <= '0;
        end
        else if (in_accept)
        begin
            phase_reg    <= phase_next;
            class_reg    <= class_next;
            id_reg       <= id_next;
            length_reg   <= length_next;
            count_reg    <= count_next;
            sum_a_reg    <= sum_a_next;
            sum_b_reg    <= sum_b_next;
            rx_sum_a_reg <= rx_sum_a_next;
        end
    end

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= emit;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (in_accept && emit)
        begin
            out_kind_reg <= out_kind_next;
            out_data_reg <= out_data_next;
        end
    end

    // A payload byte accepted in the payload phase shows up as a payload item.
    a_payload_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && phase_reg == PH_PAYLOAD)
        |=> (out_valid_reg && out_kind_reg == EV_PAYLOAD))
        else $error("payload byte did not produce a payload item");

    // While in the payload phase the count stays below the declared length.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD) |-> (count_reg < length_reg))
        else $error("payload count reached the frame length inside the payload");

    // A payload item's index lies within its frame's length.
    a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_kind_reg == EV_PAYLOAD)
        |-> (out_data_reg.byte_index < out_data_reg.payload_length))
        else $error("payload index outside the declared length");

    // An oversized length sends the parser back to sync hunting.
    a_too_long_drops: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && phase_reg == PH_LEN_HI && full_length > max_len_reg)
        |=> (phase_reg == PH_SYNC1 && out_valid_reg && out_kind_reg == EV_TOO_LONG))
        else $error("oversized frame was not dropped");

endmodule

`default_nettype wire

// ===== verif/ufr_checker.sv =====
`timescale 1ns / 1ps

// Watches the byte input, the result output and the limit write channel of the
// frame receiver. It tracks the parser on its own, queues the result items each
// accepted byte should cause, and compares every accepted result item with them.
module ufr_checker
    import ufr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [71:0] m_axis_tdata,
    input  logic [1:0]  m_axis_tuser,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [15:0] cfg_data,
    output int          pending,
    output int          fail_count,
    output logic        parser_hunting,
    output int          payload_seen,
    output int          good_seen,
    output int          bad_seen,
    output int          long_seen
);

    typedef struct packed {
        logic [1:0] kind;
        result_t    fields;
    } frame_event_t;

    // Parser state as this block should hold it.
    logic [15:0]  limit;
    logic [3:0]   phase;
    logic [7:0]   frame_class;
    logic [7:0]   frame_id;
    logic [15:0]  frame_length;
    logic [15:0]  payload_count;
    logic [7:0]   fletcher_a;
    logic [7:0]   fletcher_b;
    logic [7:0]   sent_sum_a;

    frame_event_t expected_events[$];
    int           failures;
    int           n_payload;
    int           n_good;
    int           n_bad;
    int           n_long;

    task automatic add_to_fletcher(input logic [7:0] value);
        fletcher_a = fletcher_a + value;
        fletcher_b = fletcher_b + fletcher_a;
    endtask

    task automatic queue_event(input logic [1:0] kind, input logic [15:0] index,
                               input logic [7:0] value, input logic [7:0] sa,
                               input logic [7:0] sb);
        frame_event_t ev;
        ev.kind                  = kind;
        ev.fields.msg_class      = frame_class;
        ev.fields.msg_id         = frame_id;
        ev.fields.payload_length = frame_length;
        ev.fields.byte_index     = index;
        ev.fields.payload_byte   = value;
        ev.fields.sum_a          = sa;
        ev.fields.sum_b          = sb;
        expected_events.push_back(ev);
    endtask

    // One received byte moves the parser by one step and may cause one result item.
    task automatic advance_parser(input logic [7:0] rx);
        case (phase)
            PH_SYNC2:
                phase = (rx == SYNC_SECOND) ? PH_CLASS : PH_SYNC1;
            PH_CLASS:
            begin
                frame_class = rx;
                add_to_fletcher(rx);
                phase = PH_ID;
            end
            PH_ID:
            begin
                frame_id = rx;
                add_to_fletcher(rx);
                phase = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                frame_length = {8'd0, rx};
                add_to_fletcher(rx);
                phase = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                frame_length = {rx, frame_length[7:0]};
                add_to_fletcher(rx);
                payload_count = '0;
                if (frame_length > limit)
                begin
                    queue_event(EV_TOO_LONG, '0, '0, '0, '0);
                    phase = PH_SYNC1;
                end
                else if (frame_length == 16'd0)
                    phase = PH_CK_A;
                else
                    phase = PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                add_to_fletcher(rx);
                queue_event(EV_PAYLOAD, payload_count, rx, '0, '0);
                payload_count = payload_count + 16'd1;
                if (payload_count >= frame_length)
                    phase = PH_CK_A;
            end
            PH_CK_A:
            begin
                sent_sum_a = rx;
                phase = PH_CK_B;
            end
            PH_CK_B:
            begin
                if (sent_sum_a == fletcher_a && rx == fletcher_b)
                    queue_event(EV_GOOD, '0, '0, fletcher_a, fletcher_b);
                else
                    queue_event(EV_BAD, '0, '0, fletcher_a, fletcher_b);
                phase = PH_SYNC1;
            end
            default:
            begin
                // Sync hunting; unused phase codes behave the same way.
                fletcher_a = '0;
                fletcher_b = '0;
                phase = (rx == SYNC_FIRST) ? PH_SYNC2 : PH_SYNC1;
            end
        endcase
    endtask

    task automatic check_field(input string label, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, label, want, got);
            failures++;
        end
    endtask

    // Compare results, then predict from the accepted byte, then take limit writes.
    always @(posedge clk or negedge rst_n)
    begin
        frame_event_t want;
        result_t      seen;
        if (!rst_n)
        begin
            expected_events.delete();
            limit          = MAX_LENGTH_RESET;
            phase          = PH_SYNC1;
            frame_class    = '0;
            frame_id       = '0;
            frame_length   = '0;
            payload_count  = '0;
            fletcher_a     = '0;
            fletcher_b     = '0;
            sent_sum_a     = '0;
            failures       = 0;
            n_payload      = 0;
            n_good         = 0;
            n_bad          = 0;
            n_long         = 0;
            pending        <= 0;
            fail_count     <= 0;
            parser_hunting <= 1'b1;
            payload_seen   <= 0;
            good_seen      <= 0;
            bad_seen       <= 0;
            long_seen      <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen = m_axis_tdata;
                if (expected_events.size() == 0)
                begin
                    $display("%0t ns: result item mismatch, expected none, actual kind %0d data 0x%h",
                             $time, m_axis_tuser, m_axis_tdata);
                    failures++;
                end
                else
                begin
                    want = expected_events.pop_front();
                    check_field("event_kind", want.kind, m_axis_tuser);
                    check_field("msg_class", want.fields.msg_class, seen.msg_class);
                    check_field("msg_id", want.fields.msg_id, seen.msg_id);
                    check_field("payload_length", want.fields.payload_length,
                                seen.payload_length);
                    check_field("byte_index", want.fields.byte_index, seen.byte_index);
                    check_field("payload_byte", want.fields.payload_byte,
                                seen.payload_byte);
                    check_field("sum_a", want.fields.sum_a, seen.sum_a);
                    check_field("sum_b", want.fields.sum_b, seen.sum_b);
                    case (want.kind)
                        EV_PAYLOAD: n_payload++;
                        EV_GOOD:    n_good++;
                        EV_BAD:     n_bad++;
                        default:    n_long++;
                    endcase
                end
            end

            if (s_axis_tvalid && s_axis_tready)
                advance_parser(s_axis_tdata);

            if (cfg_valid && cfg_ready)
                limit = cfg_data;

            pending        <= expected_events.size();
            fail_count     <= failures;
            parser_hunting <= (phase == PH_SYNC1);
            payload_seen   <= n_payload;
            good_seen      <= n_good;
            bad_seen       <= n_bad;
            long_seen      <= n_long;
        end
    end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import ufr_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_STALL  = 300;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'd0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data      = 16'd0;

    int          pending;
    int          fail_count;
    logic        parser_hunting;
    int          payload_seen;
    int          good_seen;
    int          bad_seen;
    int          long_seen;

    // Stimulus control.
    bit          sender_idle_en   = 1'b1;
    bit          receiver_idle_en = 1'b1;
    int          hold_requests    = 0;
    int          holds_done       = 0;
    int          stall_left       = 0;
    int          bytes_sent       = 0;
    int          cycle_count      = 0;
    logic [15:0] limit_now        = MAX_LENGTH_RESET;
    logic [7:0]  tx_sum_a;
    logic [7:0]  tx_sum_b;

    ubx_frame_receiver dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    ufr_checker frame_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .pending        (pending),
        .fail_count     (fail_count),
        .parser_hunting (parser_hunting),
        .payload_seen   (payload_seen),
        .good_seen      (good_seen),
        .bad_seen       (bad_seen),
        .long_seen      (long_seen)
    );

    always #5 clk = ~clk;

    // Result side: random stalls, plus a long hold-off whenever one is requested.
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (holds_done != hold_requests)
        begin
            m_axis_tready <= 1'b0;
            stall_left <= LONG_STALL - 1;
            holds_done <= holds_done + 1;
        end
        else if (receiver_idle_en && $urandom_range(99) < 12)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= 1'b1;
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    // Offer one byte, after a random gap now and then, and wait until it is taken.
    task automatic send_byte(input logic [7:0] value);
        if (sender_idle_en && $urandom_range(99) < 12)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        do @(posedge clk); while (!s_axis_tready);
        bytes_sent++;
    endtask

    task automatic send_summed(input logic [7:0] value);
        tx_sum_a = tx_sum_a + value;
        tx_sum_b = tx_sum_b + tx_sum_a;
        send_byte(value);
    endtask

    // Stop sending and wait until every expected result item has arrived.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        limit_now = value;
    endtask

    // Feed zero bytes until the parser is back to sync hunting.
    task automatic resync();
        drain();
        while (!parser_hunting)
        begin
            send_byte(8'h00);
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // One frame. Corrupt: 0 none, 1 sum A, 2 sum B, 3 both. Optionally the limit
    // is rewritten just before the high length byte.
    task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
                              input logic [15:0] len, input int corrupt,
                              input bit switch_limit, input logic [15:0] new_limit);
        int         i;
        logic [7:0] ck_a;
        logic [7:0] ck_b;
        tx_sum_a = '0;
        tx_sum_b = '0;
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_summed(cls);
        send_summed(id);
        send_summed(len[7:0]);
        if (switch_limit)
        begin
            drain();
            write_limit(new_limit);
        end
        send_summed(len[15:8]);
        if (len <= limit_now)
        begin
            for (i = 0; i < len; i++)
                send_summed(8'($urandom_range(255)));
            ck_a = tx_sum_a;
            ck_b = tx_sum_b;
            if (corrupt == 1 || corrupt == 3)
                ck_a = ck_a ^ 8'($urandom_range(1, 255));
            if (corrupt >= 2)
                ck_b = ck_b ^ 8'($urandom_range(1, 255));
            send_byte(ck_a);
            send_byte(ck_b);
        end
    endtask

    task automatic random_frame();
        int          pick;
        int          corrupt;
        logic [15:0] len;
        pick    = int'($urandom_range(99));
        corrupt = ($urandom_range(99) < 12) ? int'($urandom_range(1, 3)) : 0;
        if (pick < 10)
            len = 16'd0;
        else if (pick < 75)
            len = 16'($urandom_range(1, 12));
        else if (pick < 92 || limit_now == 16'hFFFF)
            len = 16'($urandom_range(13, 48));
        else
            len = 16'($urandom_range(65535, limit_now + 1));
        send_frame(8'($urandom_range(255)), 8'($urandom_range(255)), len, corrupt,
                   1'b0, '0);
    endtask

    // Random line noise; a stray first sync byte is followed by a wrong second one.
    task automatic noise_burst();
        int         n;
        logic [7:0] value;
        n = int'($urandom_range(1, 6));
        repeat (n)
        begin
            value = 8'($urandom_range(255));
            send_byte(value);
            if (value == SYNC_FIRST)
            begin
                value = 8'($urandom_range(255));
                send_byte((value == SYNC_SECOND) ? 8'h00 : value);
            end
        end
    endtask

    // A frame cut off somewhere in its header.
    task automatic broken_frame();
        int n;
        n = int'($urandom_range(0, 3));
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        repeat (n) send_byte(8'($urandom_range(255)));
    endtask

    task automatic run_traffic(input int byte_goal, input bit allow_broken);
        int goal;
        int pick;
        goal = bytes_sent + byte_goal;
        while (bytes_sent < goal)
        begin
            pick = int'($urandom_range(99));
            if (pick < 80 || (!allow_broken && pick >= 90))
                random_frame();
            else if (pick < 90)
                noise_burst();
            else
                broken_frame();
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: noise extremes, a wrong second sync byte that is itself a
        // first sync byte, an empty frame, a bad checksum and a length just over.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_frame(8'h00, 8'hFF, 16'd0, 0, 1'b0, '0);
        send_frame(8'hFF, 8'h00, 16'd1, 3, 1'b0, '0);
        send_frame(8'h0A, 8'h5C, MAX_LENGTH_RESET + 16'd1, 0, 1'b0, '0);
        drain();

        // Limit at its reset value.
        run_traffic(260, 1'b1);
        drain();

        // Limit zero: only empty frames pass.
        write_limit(16'd0);
        resync();
        send_frame(8'h01, 8'h02, 16'd0, 0, 1'b0, '0);
        send_frame(8'h01, 8'h03, 16'd1, 0, 1'b0, '0);
        run_traffic(140, 1'b1);

        // Limit raised between the two length bytes of a frame.
        resync();
        send_frame(8'h06, 8'h01, 16'd5, 0, 1'b1, 16'hFFFF);

        // Full limit: a stretch without idling, then a long frame and a long
        // output hold-off while bytes keep coming.
        sender_idle_en   = 1'b0;
        receiver_idle_en = 1'b0;
        run_traffic(180, 1'b0);
        sender_idle_en   = 1'b1;
        receiver_idle_en = 1'b1;
        send_frame(8'h0D, 8'h07, 16'd300, 0, 1'b0, '0);
        hold_requests++;
        run_traffic(130, 1'b0);
        drain();

        // Limit 40: exactly at the limit and one over it.
        write_limit(16'd40);
        resync();
        send_frame(8'h02, 8'h13, 16'd40, 0, 1'b0, '0);
        send_frame(8'h02, 8'h14, 16'd41, 0, 1'b0, '0);
        run_traffic(260, 1'b1);
        drain();

        // A random limit for the rest.
        write_limit(16'($urandom_range(1, 100)));
        run_traffic(100, 1'b1);
        drain();

        $display("Sent %0d bytes under payload limits 512, 0, 65535, 40 and %0d.",
                 bytes_sent, limit_now);
        $display("Checked %0d payload items, %0d good, %0d bad and %0d oversized frames.",
                 payload_seen, good_seen, bad_seen, long_seen);
        if (fail_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
